/* hdl/ats_pkg.sv */
// Shared types and constants of the volatility trailing stop.
`default_nettype none
package ats_pkg;

	localparam int PRICE_W = 32;
	localparam int STOP_W = 35;
	localparam int SUM_W = 40;
	localparam int DIST_W = 41;
	localparam int DIV_W = 52;
	localparam int DIV_STEPS = 4;
	localparam int DEN_W = 8;
	localparam int ADDR_W = 3;
	localparam int WINDOW_MAX_DEF = 128;
	localparam int LEN_DEFAULT = 100;
	localparam int FAC_DEFAULT = 30;
	localparam int EMA_DEN = 11;
	localparam int EMA_ROUND = 5;
	localparam int DIST_DEN = 10;
	localparam int DIST_ROUND = 1280;
	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_FACTOR = 1'b1;
	localparam logic signed [41:0] SAT_HI = 42'sd17179869183;
	localparam logic signed [41:0] SAT_LO = -42'sd17179869184;

	typedef struct packed {
		logic first_bar;
		logic [PRICE_W-1:0] close_price;
		logic [PRICE_W-1:0] high_price;
		logic [PRICE_W-1:0] low_price;
	} bar_t;

	typedef struct packed {
		logic signed [STOP_W-1:0] stop_level;
		logic stop_above_close;
	} stop_t;

	typedef struct packed {
		logic first;
		logic [PRICE_W-1:0] close;
		logic [PRICE_W-1:0] high;
		logic [PRICE_W-1:0] low;
		logic [PRICE_W-1:0] span;
	} entry_t;

	typedef struct packed {
		logic valid;
		entry_t entry;
	} queue_head_t;

	typedef struct packed {
		logic [1:0] count;
	} front_stat_t;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic pop;
		logic busy;
	} back_stat_t;

endpackage
`default_nettype wire

/* hdl/ats_chan_if.sv */
// Valid/ready channel carrying one item per handshake.
`default_nettype none
interface ats_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/ats_front.sv */
// Front end: takes bars, forms the bar span and queues them for the back end.
`default_nettype none
module ats_front (
	input wire logic clk,
	input wire logic arst_n,
	ats_chan_if.sink bar_in,
	input wire logic pop,
	output ats_pkg::queue_head_t head,
	output ats_pkg::front_stat_t stat
);
	ats_pkg::entry_t slot_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] count_q;
	logic push;
	ats_pkg::entry_t ent;

	assign bar_in.ready = (count_q != 2'd2);
	assign push = bar_in.valid && bar_in.ready;

	always_comb begin
		ent.first = bar_in.data.first_bar;
		ent.close = bar_in.data.close_price;
		ent.high = bar_in.data.high_price;
		ent.low = bar_in.data.low_price;
		ent.span = (bar_in.data.high_price >= bar_in.data.low_price) ?
			bar_in.data.high_price - bar_in.data.low_price : '0;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assign head.valid = (count_q != 2'd0);
	assign head.entry = slot_q[rd_q];
	assign stat.count = count_q;
endmodule
`default_nettype wire

/* hdl/ats_div.sv */
// Shared iterative divider, four quotient bits per cycle.
`default_nettype none
module ats_div (
	input wire logic clk,
	input wire logic arst_n,
	input ats_pkg::div_req_t req,
	output ats_pkg::div_rsp_t rsp
);
	localparam int ITER = ats_pkg::DIV_W / ats_pkg::DIV_STEPS;
	localparam int CNT_W = $clog2(ITER + 1);

	logic [ats_pkg::DIV_W-1:0] sh_q;
	logic [ats_pkg::DEN_W-1:0] rem_q;
	logic [ats_pkg::DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic done_q;
	logic [ats_pkg::DIV_W-1:0] sh_nx;
	logic [ats_pkg::DEN_W-1:0] rem_nx;

	always_comb begin
		logic [ats_pkg::DEN_W:0] r;
		sh_nx = sh_q;
		rem_nx = rem_q;
		for (int i = 0; i < ats_pkg::DIV_STEPS; i++) begin
			r = {rem_nx, sh_nx[ats_pkg::DIV_W-1]};
			sh_nx = {sh_nx[ats_pkg::DIV_W-2:0], 1'b0};
			if (r >= {1'b0, den_q}) begin
				r = r - {1'b0, den_q};
				sh_nx[0] = 1'b1;
			end
			rem_nx = r[ats_pkg::DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (req.start) begin
				cnt_q <= CNT_W'(ITER);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sh_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (cnt_q != '0) begin
			sh_q <= sh_nx;
			rem_q <= rem_nx;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = sh_q;
endmodule
`default_nettype wire

/* hdl/ats_back.sv */
// Back end: true range window, average, EMA, stop distance and trailing stop.
`default_nettype none
module ats_back #(
	parameter int WINDOW_MAX = ats_pkg::WINDOW_MAX_DEF,
	localparam int PW = $clog2(WINDOW_MAX),
	localparam int CW = $clog2(WINDOW_MAX + 1)
) (
	input wire logic clk,
	input wire logic arst_n,
	input ats_pkg::queue_head_t head,
	input wire logic [CW-1:0] len,
	input wire logic [7:0] fac,
	output ats_pkg::div_req_t dreq,
	input ats_pkg::div_rsp_t drsp,
	ats_chan_if.source stop_out,
	output ats_pkg::back_stat_t stat
);
	typedef enum logic [2:0] {
		S_IDLE, S_RANGE, S_SUM, S_AVG, S_EMA, S_MUL, S_DIST, S_STOP
	} state_t;

	state_t state_q;
	logic [31:0] ring_q [WINDOW_MAX];
	logic [31:0] rd_q;
	logic [31:0] tr_q;
	logic first_q;
	logic [ats_pkg::SUM_W-1:0] sum_q;
	logic [CW-1:0] bars_q;
	logic [PW-1:0] ptr_q;
	logic [ats_pkg::PRICE_W-1:0] pclose_q;
	logic signed [ats_pkg::STOP_W-1:0] pstop_q;
	logic [ats_pkg::SUM_W-1:0] smooth_q;
	logic [ats_pkg::DIST_W-1:0] dist_q;
	logic dstart_q;
	logic [ats_pkg::DIV_W-1:0] dnum_q;
	logic [ats_pkg::DEN_W-1:0] dden_q;
	ats_pkg::stop_t out_q;
	logic out_v_q;

	ats_pkg::entry_t e;
	logic [31:0] tr;
	logic [PW-1:0] back_idx;
	logic [ats_pkg::SUM_W-1:0] sum_nx;
	logic [CW-1:0] bars_nx;
	logic [CW-1:0] n;
	logic [PW-1:0] ptr_nx;
	logic [ats_pkg::SUM_W-1:0] avg;
	logic [ats_pkg::DIV_W-1:0] ema_num;
	logic [48:0] prod;
	ats_pkg::stop_t res;
	logic pop;

	assign e = head.entry;

	always_comb begin
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] pe;
		a = (e.high >= pclose_q) ? e.high - pclose_q : pclose_q - e.high;
		b = (e.low >= pclose_q) ? e.low - pclose_q : pclose_q - e.low;
		tr = e.span;
		if (!e.first) begin
			if (a > tr) tr = a;
			if (b > tr) tr = b;
		end
		pe = e.first ? 32'd0 : 32'(ptr_q);
		back_idx = PW'((pe >= 32'(len)) ? pe - 32'(len) : pe + 32'(WINDOW_MAX) - 32'(len));
	end

	always_comb begin
		if (bars_q >= len) sum_nx = sum_q + ats_pkg::SUM_W'(tr_q) - ats_pkg::SUM_W'(rd_q);
		else sum_nx = sum_q + ats_pkg::SUM_W'(tr_q);
		bars_nx = (32'(bars_q) < WINDOW_MAX) ? bars_q + CW'(1) : bars_q;
		n = (bars_nx < len) ? bars_nx : len;
		ptr_nx = (32'(ptr_q) + 32'd1 >= WINDOW_MAX) ? '0 : ptr_q + PW'(1);
		avg = (drsp.quot[ats_pkg::DIV_W-1:ats_pkg::SUM_W] != '0) ? '1 :
			drsp.quot[ats_pkg::SUM_W-1:0];
		ema_num = (ats_pkg::DIV_W'(smooth_q) << 3) + ats_pkg::DIV_W'(smooth_q) +
			(ats_pkg::DIV_W'(avg) << 1) + ats_pkg::DIV_W'(ats_pkg::EMA_ROUND);
		prod = 49'(48'(smooth_q) * 48'(fac)) + 49'(ats_pkg::DIST_ROUND);
	end

	always_comb begin
		logic signed [41:0] cw;
		logic signed [41:0] upw;
		logic signed [41:0] dnw;
		logic signed [ats_pkg::STOP_W-1:0] ci;
		logic signed [ats_pkg::STOP_W-1:0] cp;
		logic signed [ats_pkg::STOP_W-1:0] up;
		logic signed [ats_pkg::STOP_W-1:0] dn;
		logic signed [ats_pkg::STOP_W-1:0] st;
		cw = $signed({10'b0, e.close});
		upw = cw + $signed({1'b0, dist_q});
		dnw = cw - $signed({1'b0, dist_q});
		up = (upw > ats_pkg::SAT_HI) ? ats_pkg::SAT_HI[34:0] : upw[34:0];
		dn = (dnw < ats_pkg::SAT_LO) ? ats_pkg::SAT_LO[34:0] : dnw[34:0];
		ci = $signed({3'b0, e.close});
		cp = $signed({3'b0, pclose_q});
		if (first_q) st = dn;
		else if (ci == pstop_q) st = pstop_q;
		else if (cp < pstop_q && ci < pstop_q) st = (pstop_q < up) ? pstop_q : up;
		else if (cp > pstop_q && ci > pstop_q) st = (pstop_q > dn) ? pstop_q : dn;
		else st = (ci > pstop_q) ? dn : up;
		res.stop_level = st;
		res.stop_above_close = (st > ci);
	end

	assign pop = (state_q == S_STOP) && (!out_v_q || stop_out.ready);

	always_ff @(posedge clk) begin
		if (state_q == S_RANGE) rd_q <= ring_q[back_idx];
		if (state_q == S_SUM) ring_q[ptr_q] <= tr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sum_q <= '0;
			bars_q <= '0;
			ptr_q <= '0;
			pclose_q <= '0;
			pstop_q <= '0;
			smooth_q <= '0;
			dstart_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			dstart_q <= 1'b0;
			if (out_v_q && stop_out.ready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (head.valid) state_q <= S_RANGE;
				end
				S_RANGE: begin
					tr_q <= tr;
					first_q <= e.first;
					if (e.first) begin
						sum_q <= '0;
						bars_q <= '0;
						ptr_q <= '0;
					end
					state_q <= S_SUM;
				end
				S_SUM: begin
					sum_q <= sum_nx;
					bars_q <= bars_nx;
					ptr_q <= ptr_nx;
					dnum_q <= {sum_nx, 8'b0} + ats_pkg::DIV_W'(n >> 1);
					dden_q <= ats_pkg::DEN_W'(n);
					dstart_q <= 1'b1;
					state_q <= S_AVG;
				end
				S_AVG: begin
					if (drsp.done) begin
						if (first_q) begin
							smooth_q <= avg;
							state_q <= S_MUL;
						end else begin
							dnum_q <= ema_num;
							dden_q <= ats_pkg::DEN_W'(ats_pkg::EMA_DEN);
							dstart_q <= 1'b1;
							state_q <= S_EMA;
						end
					end
				end
				S_EMA: begin
					if (drsp.done) begin
						smooth_q <= drsp.quot[ats_pkg::SUM_W-1:0];
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					dnum_q <= ats_pkg::DIV_W'(prod >> 8);
					dden_q <= ats_pkg::DEN_W'(ats_pkg::DIST_DEN);
					dstart_q <= 1'b1;
					state_q <= S_DIST;
				end
				S_DIST: begin
					if (drsp.done) begin
						dist_q <= drsp.quot[ats_pkg::DIST_W-1:0];
						state_q <= S_STOP;
					end
				end
				S_STOP: begin
					if (pop) begin
						out_q <= res;
						out_v_q <= 1'b1;
						pclose_q <= e.close;
						pstop_q <= res.stop_level;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign dreq.start = dstart_q;
	assign dreq.num = dnum_q;
	assign dreq.den = dden_q;
	assign stop_out.valid = out_v_q;
	assign stop_out.data = out_q;
	assign stat.pop = pop;
	assign stat.busy = (state_q != S_IDLE);
endmodule
`default_nettype wire

/* hdl/atr_trailing_stop.sv */
// Top level of the volatility trailing stop: registers, front end, divider, back end.
// The stop of each accepted bar is set by three passes of the shared divider (two on a
// first bar) plus the window and stop steps. The back end works on one bar at a time and
// holds in its stop step until the previous result is taken; a two-item queue takes bars
// meanwhile.
// Reset clears the running state and sets window_length to 100, factor_tenths to 30.
// The true range ring is not cleared; entries are used only after being written.
`default_nettype none
module atr_trailing_stop #(
	parameter int WINDOW_MAX = ats_pkg::WINDOW_MAX_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	ats_chan_if.sink bar_in,
	ats_chan_if.source stop_out,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ats_pkg::ADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int CW = $clog2(WINDOW_MAX + 1);

	logic [7:0] wl_q;
	logic [7:0] fac_q;
	logic [7:0] len_sel;
	logic [CW-1:0] len;
	logic [7:0] fac;
	ats_pkg::queue_head_t head;
	ats_pkg::front_stat_t fstat;
	ats_pkg::back_stat_t bstat;
	ats_pkg::div_req_t dreq;
	ats_pkg::div_rsp_t drsp;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= 8'(ats_pkg::LEN_DEFAULT);
			fac_q <= 8'(ats_pkg::FAC_DEFAULT);
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == ats_pkg::REG_WINDOW) wl_q <= pwdata[7:0];
			else fac_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == ats_pkg::REG_FACTOR) ? {24'b0, fac_q} : {24'b0, wl_q};

	always_comb begin
		len_sel = (wl_q == '0) ? 8'(ats_pkg::LEN_DEFAULT) : wl_q;
		len = (32'(len_sel) > WINDOW_MAX) ? CW'(WINDOW_MAX) : CW'(len_sel);
		fac = (fac_q == '0) ? 8'(ats_pkg::FAC_DEFAULT) : fac_q;
	end

	ats_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.bar_in(bar_in),
		.pop(bstat.pop),
		.head(head),
		.stat(fstat)
	);

	ats_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.rsp(drsp)
	);

	ats_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.len(len),
		.fac(fac),
		.dreq(dreq),
		.drsp(drsp),
		.stop_out(stop_out),
		.stat(bstat)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.pop |-> fstat.count != 2'd0)
		else $error("item taken from an empty queue");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.count != 2'd3)
		else $error("queue count out of range");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stop_out.valid) |-> $past(bstat.busy))
		else $error("result appeared without back end work");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.count == 2'd2 |-> !bar_in.ready)
		else $error("full queue still takes items");
endmodule
`default_nettype wire

/* tb/tb_atr_trailing_stop.sv */
// Self-checking testbench of the volatility trailing stop: random bars, APB setup, stop checks.
`default_nettype none
module tb_atr_trailing_stop;
	import ats_pkg::*;

	localparam logic [ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};
	localparam logic [ADDR_W-1:0] FACTOR_ADDR = {REG_FACTOR, 2'b00};
	localparam int RING_DEPTH = 128;
	localparam longint STOP_TOP = 64'sd17179869183;
	localparam longint STOP_BOTTOM = -64'sd17179869184;
	localparam bit [63:0] SUM_MASK = (64'd1 << 40) - 1;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	ats_chan_if #(.T(bar_t)) bar_ch ();
	ats_chan_if #(.T(stop_t)) stop_ch ();

	atr_trailing_stop dut (
		.clk(clk),
		.arst_n(arst_n),
		.bar_in(bar_ch),
		.stop_out(stop_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	bar_t pending_bars[$];
	stop_t expected_stops[$];
	bit idling_on = 1'b1;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned send_gap = 0;
	int unsigned recv_stall = 0;

	bit [7:0] cfg_window = 8'd100;
	bit [7:0] cfg_factor = 8'd30;
	bit [31:0] tr_ring[RING_DEPTH];
	bit [63:0] range_sum = 0;
	int unsigned bars_in_series = 0;
	int unsigned ring_slot = 0;
	bit [63:0] last_close = 0;
	longint last_stop = 0;
	bit [63:0] ema_range = 0;

	function automatic longint clamp_stop(longint v);
		if (v > STOP_TOP) begin
			return STOP_TOP;
		end
		if (v < STOP_BOTTOM) begin
			return STOP_BOTTOM;
		end
		return v;
	endfunction

	function automatic void predict_stop(bar_t b);
		bit [63:0] c, h, l, tr, a, d, avg, n, distance, fac;
		int unsigned len;
		longint ci, cp, bp, up, dn, st;
		stop_t r;
		c = b.close_price;
		h = b.high_price;
		l = b.low_price;
		len = (cfg_window == 0) ? 100 : cfg_window;
		if (len > RING_DEPTH) begin
			len = RING_DEPTH;
		end
		fac = (cfg_factor == 0) ? 30 : cfg_factor;
		tr = (h >= l) ? h - l : 0;
		if (b.first_bar) begin
			bars_in_series = 0;
			range_sum = 0;
			ring_slot = 0;
		end else begin
			a = (h >= last_close) ? h - last_close : last_close - h;
			d = (l >= last_close) ? l - last_close : last_close - l;
			if (a > tr) begin
				tr = a;
			end
			if (d > tr) begin
				tr = d;
			end
		end
		tr = tr & 64'hFFFF_FFFF;
		if (bars_in_series >= len) begin
			range_sum = (range_sum + tr
				- tr_ring[(ring_slot + RING_DEPTH - len) % RING_DEPTH]) & SUM_MASK;
		end else begin
			range_sum = (range_sum + tr) & SUM_MASK;
		end
		tr_ring[ring_slot] = tr[31:0];
		ring_slot = (ring_slot + 1) % RING_DEPTH;
		if (bars_in_series < RING_DEPTH) begin
			bars_in_series++;
		end
		n = (bars_in_series < len) ? bars_in_series : len;
		avg = ((range_sum << 8) + n / 2) / n;
		if (avg > SUM_MASK) begin
			avg = SUM_MASK;
		end
		if (b.first_bar) begin
			ema_range = avg;
		end else begin
			ema_range = ((9 * ema_range + 2 * avg + 5) / 11) & SUM_MASK;
		end
		distance = (ema_range * fac + 1280) / 2560;
		if (distance > (64'd1 << 40)) begin
			distance = 64'd1 << 40;
		end
		ci = longint'(c);
		cp = longint'(last_close);
		bp = last_stop;
		up = clamp_stop(ci + longint'(distance));
		dn = clamp_stop(ci - longint'(distance));
		if (b.first_bar) begin
			st = dn;
		end else if (ci == bp) begin
			st = bp;
		end else if (cp < bp && ci < bp) begin
			st = (bp < up) ? bp : up;
		end else if (cp > bp && ci > bp) begin
			st = (bp > dn) ? bp : dn;
		end else begin
			st = (ci > bp) ? dn : up;
		end
		last_close = c;
		last_stop = st;
		r.stop_level = st[STOP_W-1:0];
		r.stop_above_close = (st > ci);
		expected_stops.push_back(r);
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!idling_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 90);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_ch.valid <= 1'b0;
			bar_ch.data <= '0;
		end else begin
			if (bar_ch.valid && bar_ch.ready) begin
				predict_stop(bar_ch.data);
			end
			if (!bar_ch.valid || bar_ch.ready) begin
				if (send_gap > 0) begin
					bar_ch.valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_bars.size() > 0) begin
					bar_ch.data <= pending_bars.pop_front();
					bar_ch.valid <= 1'b1;
					send_gap <= pick_gap();
				end else begin
					bar_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		stop_t want;
		if (!arst_n) begin
			stop_ch.ready <= 1'b0;
		end else begin
			if (stop_ch.valid && stop_ch.ready) begin
				if (expected_stops.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Unexpected item: stop %0d above %0b",
							stop_ch.data.stop_level, stop_ch.data.stop_above_close);
					end
				end else begin
					want = expected_stops.pop_front();
					if (stop_ch.data.stop_level !== want.stop_level
						|| stop_ch.data.stop_above_close !== want.stop_above_close) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch: stop exp %0d got %0d, above exp %0b got %0b",
								want.stop_level, stop_ch.data.stop_level,
								want.stop_above_close, stop_ch.data.stop_above_close);
						end
					end
				end
			end
			if (recv_stall > 0) begin
				stop_ch.ready <= 1'b0;
				recv_stall <= recv_stall - 1;
			end else begin
				stop_ch.ready <= 1'b1;
				recv_stall <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == WINDOW_ADDR) begin
			cfg_window = value[7:0];
		end else begin
			cfg_factor = value[7:0];
		end
	endtask

	task automatic add_bar(input bit first, input bit [31:0] c, input bit [31:0] h,
		input bit [31:0] l);
		bar_t b;
		b.first_bar = first;
		b.close_price = c;
		b.high_price = h;
		b.low_price = l;
		pending_bars.push_back(b);
	endtask

	function automatic bit [31:0] clamp_price(longint v);
		if (v < 0) begin
			return 32'd0;
		end
		if (v > 64'sd4294967295) begin
			return 32'hFFFF_FFFF;
		end
		return v[31:0];
	endfunction

	task automatic add_series(input int count);
		longint px, drift, spread, hi, lo;
		int i;
		px = $urandom_range(0, 9) == 0 ? longint'($urandom_range(0, 3)) * 64'sd1431655765
			: longint'($urandom);
		spread = longint'(1) << $urandom_range(0, 26);
		drift = 0;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				add_bar(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
			end else begin
				if ($urandom_range(0, 11) == 0) begin
					drift = longint'($urandom_range(0, 2 * 64)) - 64;
					drift = drift * spread / 16;
				end
				px = longint'(clamp_price(px + drift
					+ longint'($urandom_range(0, 2000)) * spread / 1000 - spread));
				hi = px + longint'($urandom_range(0, 1000)) * spread / 1000;
				lo = px - longint'($urandom_range(0, 1000)) * spread / 1000;
				if ($urandom_range(0, 30) == 0) begin
					add_bar(i == 0 || $urandom_range(0, 80) == 0, px[31:0],
						clamp_price(lo), clamp_price(hi));
				end else begin
					add_bar(i == 0 || $urandom_range(0, 80) == 0, px[31:0],
						clamp_price(hi), clamp_price(lo));
				end
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_bars.size() > 0 || bar_ch.valid || expected_stops.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int p;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_bar(1'b0, 32'd1000, 32'd1100, 32'd900);
		add_bar(1'b0, 32'd1200, 32'd1250, 32'd1150);
		add_bar(1'b1, 32'd0, 32'd0, 32'd0);
		add_bar(1'b0, 32'd0, 32'd0, 32'd0);
		add_bar(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		add_bar(1'b0, 32'd0, 32'hFFFF_FFFF, 32'd0);
		add_bar(1'b0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		add_bar(1'b1, 32'd5000, 32'd4000, 32'd6000);
		add_bar(1'b0, 32'd5100, 32'd5150, 32'd5050);
		add_bar(1'b0, 32'd5300, 32'd5350, 32'd5250);
		add_bar(1'b0, 32'd5500, 32'd5550, 32'd5450);
		add_bar(1'b0, 32'd4000, 32'd5500, 32'd3900);
		add_bar(1'b0, 32'd3800, 32'd3900, 32'd3700);
		add_bar(1'b0, 32'd3600, 32'd3700, 32'd3500);
		add_bar(1'b0, 32'd6000, 32'd6100, 32'd3500);
		add_bar(1'b0, 32'd6200, 32'd6300, 32'd6100);
		add_bar(1'b1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
		add_bar(1'b0, 32'h5555_5555, 32'hFFFF_FFFF, 32'h5555_5555);
		add_series(170);
		wait_idle();

		for (p = 0; p < 7; p++) begin
			idling_on = (p != 2);
			case (p)
				0: begin
					apb_write(WINDOW_ADDR, 32'd1);
					apb_write(FACTOR_ADDR, 32'd1);
				end
				1: begin
					apb_write(WINDOW_ADDR, 32'd128);
					apb_write(FACTOR_ADDR, 32'd255);
				end
				2: begin
					apb_write(WINDOW_ADDR, 32'd0);
					apb_write(FACTOR_ADDR, 32'd0);
				end
				3: begin
					apb_write(WINDOW_ADDR, 32'd255);
					apb_write(FACTOR_ADDR, 32'd10);
				end
				4: begin
					apb_write(WINDOW_ADDR, 32'd2);
					apb_write(FACTOR_ADDR, 32'd30);
				end
				default: begin
					apb_write(WINDOW_ADDR, $urandom_range(0, 255));
					apb_write(FACTOR_ADDR, $urandom_range(0, 255));
				end
			endcase
			while (pending_bars.size() < 130) begin
				add_series($urandom_range(5, 60));
			end
			if (p == 1) begin
				wait (pending_bars.size() < 80);
				wait_idle();
				apb_write(WINDOW_ADDR, 32'd5);
				add_series(40);
			end
			wait_idle();
		end

		if (expected_stops.size() != 0) begin
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* sim.f */
hdl/ats_pkg.sv
hdl/ats_chan_if.sv
hdl/ats_front.sv
hdl/ats_div.sv
hdl/ats_back.sv
hdl/atr_trailing_stop.sv
tb/tb_atr_trailing_stop.sv
